@@ rtl/lmsd_pkg.sv @@
// Shared constants, command codes and interface types of the LED matrix scan driver.
`default_nettype none

package lmsd_pkg;

    localparam int unsigned STORE_DEPTH       = 128;
    localparam int unsigned STORE_AW          = 7;
    localparam int unsigned BYTE_W            = 8;
    localparam int unsigned BIT_W             = 3;
    localparam int unsigned CMD_W             = 2;
    localparam int unsigned ROW_W             = 4;
    localparam int unsigned BITS_PER_BYTE     = 8;
    localparam int unsigned DEF_ROW_COUNT     = 16;
    localparam int unsigned DEF_BYTES_PER_ROW = 8;

    localparam logic [BYTE_W-1:0] REPEATS_RESET = 8'd16;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [BYTE_W-1:0]   data;
    } store_wr_t;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic                valid;
        logic [STORE_AW-1:0] addr;
        logic [BYTE_W-1:0]   data;
    } store_rdata_t;

    typedef struct packed {
        logic             serial_data;
        logic             bit_strobe;
        logic             latch_pulse;
        logic [ROW_W-1:0] row_address;
        logic             active;
    } scan_result_t;

endpackage

`default_nettype wire

@@ rtl/led_matrix_scan_driver.sv @@
// A request passes through the request register, then the result register, before it
// appears as a result; one request is taken every cycle while results are taken.
// The byte being shifted is held in a register and the next one is prefetched from the
// frame store's single read port, so every tick shifts one bit without waiting.
// Reset clears all control state; frame store entries read as zero until written, by way
// of one valid flag per entry, so no clearing pass is needed. frame_repeats resets to 16.
`default_nettype none

module led_matrix_scan_driver #(
    parameter int unsigned ROW_COUNT     = lmsd_pkg::DEF_ROW_COUNT,
    parameter int unsigned BYTES_PER_ROW = lmsd_pkg::DEF_BYTES_PER_ROW
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lmsd_pkg::BYTE_W-1:0]   cfg_wr_data,
    input  wire logic                          cmd_valid,
    output logic                               cmd_stall,
    input  wire logic [lmsd_pkg::CMD_W-1:0]    command,
    input  wire logic [lmsd_pkg::STORE_AW-1:0] byte_index,
    input  wire logic [lmsd_pkg::BYTE_W-1:0]   byte_value,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic                               serial_data,
    output logic                               bit_strobe,
    output logic                               latch_pulse,
    output logic [lmsd_pkg::ROW_W-1:0]         row_address,
    output logic                               active
);
    import lmsd_pkg::*;

    logic [BYTE_W-1:0]   frame_repeats_reg;
    logic                req_valid_reg,  req_valid_next;
    logic [CMD_W-1:0]    req_cmd_reg;
    logic [STORE_AW-1:0] req_index_reg;
    logic [BYTE_W-1:0]   req_value_reg;
    logic                res_valid_reg,  res_valid_next;
    scan_result_t        res_reg;
    scan_result_t        result;
    store_wr_t           wr;
    store_rd_t           rd;
    store_rdata_t        rdata;
    logic                res_ready;
    logic                fire;
    logic                accept;

    always_comb
    begin
        res_ready      = !res_valid_reg || !res_stall;
        fire           = req_valid_reg && res_ready;
        cmd_stall      = req_valid_reg && !res_ready;
        accept         = cmd_valid && !cmd_stall;
        req_valid_next = accept || (req_valid_reg && !fire);
        res_valid_next = res_ready ? req_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_repeats_reg <= REPEATS_RESET;
            req_valid_reg     <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                frame_repeats_reg <= cfg_wr_data;
            end
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_cmd_reg   <= command;
            req_index_reg <= byte_index;
            req_value_reg <= byte_value;
        end
        if (fire)
        begin
            res_reg <= result;
        end
    end

    lmsd_frame_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    lmsd_scan_ctrl #(
        .ROW_COUNT     (ROW_COUNT),
        .BYTES_PER_ROW (BYTES_PER_ROW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .command       (req_cmd_reg),
        .byte_index    (req_index_reg),
        .byte_value    (req_value_reg),
        .frame_repeats (frame_repeats_reg),
        .rdata         (rdata),
        .wr            (wr),
        .rd            (rd),
        .result        (result)
    );

    assign res_valid   = res_valid_reg;
    assign serial_data = res_reg.serial_data;
    assign bit_strobe  = res_reg.bit_strobe;
    assign latch_pulse = res_reg.latch_pulse;
    assign row_address = res_reg.row_address;
    assign active      = res_reg.active;

    // A request is never held back while the result register is free.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> !cmd_stall)
        else $error("request stalled with an empty result register");

    // A latch only ever accompanies a shifted bit.
    a_latch_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.latch_pulse |-> res_reg.bit_strobe)
        else $error("latch pulse without a shifted bit");

    // Serial data stays low on results that shifted nothing.
    a_data_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.bit_strobe |-> !res_reg.serial_data)
        else $error("serial data driven without a shift");

    // A request held in the request register reaches the result register once it moves.
    a_request_moves: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && res_ready |=> res_valid_reg)
        else $error("request lost between request and result registers");

endmodule

`default_nettype wire

@@ rtl/lmsd_frame_store.sv @@
// Frame store: 128-byte memory with per-entry valid flags and a registered read port.
`default_nettype none

module lmsd_frame_store (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lmsd_pkg::store_wr_t   wr,
    input  wire lmsd_pkg::store_rd_t   rd,
    output lmsd_pkg::store_rdata_t     rdata
);
    import lmsd_pkg::*;

    logic [BYTE_W-1:0]      mem_reg [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] vld_reg;
    logic [BYTE_W-1:0]      raw_reg;
    logic                   raw_vld_reg;
    logic                   byp_reg;
    logic [BYTE_W-1:0]      byp_data_reg;
    logic                   fire_reg;
    logic [STORE_AW-1:0]    addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        raw_reg      <= mem_reg[rd.addr];
        byp_data_reg <= wr.data;
        addr_reg     <= rd.addr;
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            raw_vld_reg <= 1'b0;
            byp_reg     <= 1'b0;
            fire_reg    <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            raw_vld_reg <= vld_reg[rd.addr];
            byp_reg     <= wr.en && (wr.addr == rd.addr);
            fire_reg    <= rd.en;
        end
    end

    // A write to the address being read in the same cycle is forwarded.
    always_comb
    begin
        rdata.valid = fire_reg;
        rdata.addr  = addr_reg;
        if (byp_reg)
        begin
            rdata.data = byp_data_reg;
        end
        else if (raw_vld_reg)
        begin
            rdata.data = raw_reg;
        end
        else
        begin
            rdata.data = '0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lmsd_scan_ctrl.sv @@
// Scan sequencer: byte, bit, column and row counters, pass count and the byte caches.
`default_nettype none

module lmsd_scan_ctrl #(
    parameter int unsigned ROW_COUNT     = lmsd_pkg::DEF_ROW_COUNT,
    parameter int unsigned BYTES_PER_ROW = lmsd_pkg::DEF_BYTES_PER_ROW
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           fire,
    input  wire logic [lmsd_pkg::CMD_W-1:0]     command,
    input  wire logic [lmsd_pkg::STORE_AW-1:0]  byte_index,
    input  wire logic [lmsd_pkg::BYTE_W-1:0]    byte_value,
    input  wire logic [lmsd_pkg::BYTE_W-1:0]    frame_repeats,
    input  wire lmsd_pkg::store_rdata_t         rdata,
    output lmsd_pkg::store_wr_t                 wr,
    output lmsd_pkg::store_rd_t                 rd,
    output lmsd_pkg::scan_result_t              result
);
    import lmsd_pkg::*;

    localparam int unsigned FRAME_BYTES = ROW_COUNT * BYTES_PER_ROW;
    localparam int unsigned PTR_W       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int unsigned COL_W       = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FRAME_BYTES - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(BYTES_PER_ROW - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(BITS_PER_BYTE - 1);

    logic [PTR_W-1:0]    ptr_reg,       ptr_next;
    logic [BIT_W-1:0]    bit_reg,       bit_next;
    logic [COL_W-1:0]    col_reg,       col_next;
    logic [ROW_W-1:0]    row_reg,       row_next;
    logic [BYTE_W-1:0]   passes_reg,    passes_next;
    logic                running_reg,   running_next;
    logic [BYTE_W-1:0]   cur_reg,       cur_next;
    logic [BYTE_W-1:0]   nxt_reg,       nxt_next;
    logic [STORE_AW-1:0] nxt_addr_reg,  nxt_addr_next;
    logic [BYTE_W-1:0]   byte0_reg,     byte0_next;
    logic                pf_en_reg,     pf_en_next;
    logic [STORE_AW-1:0] pf_addr_reg,   pf_addr_next;

    logic [STORE_AW-1:0] cur_addr;
    logic [PTR_W-1:0]    ptr_follow;
    logic                tick;
    logic                last_bit;
    logic                row_end;
    logic                pix;
    logic                latch;

    always_comb
    begin
        cur_addr = STORE_AW'(ptr_reg);
        tick     = fire && (command == CMD_TICK) && running_reg;
        last_bit = (bit_reg == BIT_LAST);
        row_end  = (col_reg == COL_LAST);
        pix      = cur_reg[~bit_reg];
        latch    = tick && last_bit && row_end;

        wr.en   = fire && (command == CMD_LOAD);
        wr.addr = byte_index;
        wr.data = byte_value;

        ptr_next      = ptr_reg;
        bit_next      = bit_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        passes_next   = passes_reg;
        running_next  = running_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        nxt_addr_next = nxt_addr_reg;
        byte0_next    = byte0_reg;
        pf_en_next    = 1'b0;

        if (fire && (command == CMD_START))
        begin
            passes_next  = (frame_repeats == '0) ? '0 : frame_repeats - BYTE_W'(1);
            running_next = (passes_next != '0);
            ptr_next     = '0;
            bit_next     = '0;
            col_next     = '0;
            cur_next     = byte0_reg;
            pf_en_next   = 1'b1;
        end

        if (tick)
        begin
            bit_next = last_bit ? '0 : bit_reg + BIT_W'(1);
            if (last_bit)
            begin
                // The following byte was fetched while this one was shifting.
                cur_next   = nxt_reg;
                pf_en_next = 1'b1;
                col_next   = row_end ? '0 : col_reg + COL_W'(1);
                if (row_end)
                begin
                    row_next = (row_reg == ROW_LAST) ? '0 : row_reg + ROW_W'(1);
                end
                if (ptr_reg == PTR_LAST)
                begin
                    ptr_next     = '0;
                    passes_next  = (passes_reg == '0) ? '0 : passes_reg - BYTE_W'(1);
                    running_next = (passes_next != '0);
                end
                else
                begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
            end
        end

        ptr_follow   = (ptr_next == PTR_LAST) ? '0 : ptr_next + PTR_W'(1);
        pf_addr_next = STORE_AW'(ptr_follow);

        // Keep the cached copies coherent with frame store writes.
        if (wr.en)
        begin
            if (wr.addr == cur_addr)
            begin
                cur_next = wr.data;
            end
            if (wr.addr == '0)
            begin
                byte0_next = wr.data;
            end
            if (wr.addr == nxt_addr_reg)
            begin
                nxt_next = wr.data;
            end
        end

        if (rdata.valid)
        begin
            nxt_addr_next = rdata.addr;
            nxt_next      = (wr.en && (wr.addr == rdata.addr)) ? wr.data : rdata.data;
        end

        rd.en   = pf_en_reg;
        rd.addr = pf_addr_reg;

        result.serial_data = tick && !pix;
        result.bit_strobe  = tick;
        result.latch_pulse = latch;
        result.row_address = row_next;
        result.active      = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            bit_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            passes_reg  <= '0;
            running_reg <= 1'b0;
            byte0_reg   <= '0;
            pf_en_reg   <= 1'b0;
        end
        else
        begin
            ptr_reg     <= ptr_next;
            bit_reg     <= bit_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            passes_reg  <= passes_next;
            running_reg <= running_next;
            byte0_reg   <= byte0_next;
            pf_en_reg   <= pf_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        nxt_addr_reg <= nxt_addr_next;
        pf_addr_reg  <= pf_addr_next;
    end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the LED matrix scan driver: directed table, then random phases.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lmsd_pkg::*;

    localparam int unsigned ROWS          = 16;
    localparam int unsigned ROW_BYTES     = 8;
    localparam int unsigned FRAME_BYTES   = ROWS * ROW_BYTES;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          HOLD_AT       = 400;
    localparam int          HOLD_CYCLES   = 48;
    localparam int          WATCHDOG_LIMIT = 2000;

    // The package leaves the fourth command code unnamed; the block ignores it.
    localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

    // Result patterns in field order: data, strobe, latch, row address, active.
    localparam scan_result_t NONE_IDLE = 8'b0_0_0_0000_0;
    localparam scan_result_t NONE_RUN  = 8'b0_0_0_0000_1;
    localparam scan_result_t LIT_RUN   = 8'b0_1_0_0000_1;
    localparam scan_result_t DARK_RUN  = 8'b1_1_0_0000_1;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CMD_W-1:0]     cmd;
        logic [STORE_AW-1:0]  idx;
        logic [BYTE_W-1:0]    val;
        bit                   typed;
        scan_result_t         res;
    } plan_row_t;

    localparam int PLAN_ROWS = 26;

    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b1, NONE_IDLE},
        '{ROW_REQ, CMD_RSVD,  7'd127, 8'hFF, 1'b1, NONE_IDLE},
        '{ROW_REQ, CMD_LOAD,  7'd0,   8'h80, 1'b1, NONE_IDLE},
        '{ROW_REQ, CMD_LOAD,  7'd127, 8'hFF, 1'b1, NONE_IDLE},
        '{ROW_REQ, CMD_LOAD,  7'd1,   8'h5A, 1'b1, NONE_IDLE},
        '{ROW_REQ, CMD_START, 7'd0,   8'h00, 1'b1, NONE_RUN},
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b1, LIT_RUN},
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b1, DARK_RUN},
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b0, NONE_IDLE},
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b0, NONE_IDLE},
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b0, NONE_IDLE},
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b0, NONE_IDLE},
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b0, NONE_IDLE},
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b0, NONE_IDLE},
        '{ROW_REQ, CMD_LOAD,  7'd1,   8'hC3, 1'b0, NONE_IDLE},
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b0, NONE_IDLE},
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b0, NONE_IDLE},
        '{ROW_REQ, CMD_RSVD,  7'd0,   8'h00, 1'b0, NONE_IDLE},
        '{ROW_REQ, CMD_START, 7'd0,   8'h00, 1'b0, NONE_IDLE},
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b0, NONE_IDLE},
        '{ROW_CFG, CMD_LOAD,  7'd0,   8'd1,  1'b0, NONE_IDLE},
        '{ROW_REQ, CMD_START, 7'd0,   8'h00, 1'b1, NONE_IDLE},
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b1, NONE_IDLE},
        '{ROW_CFG, CMD_LOAD,  7'd0,   8'd0,  1'b0, NONE_IDLE},
        '{ROW_REQ, CMD_START, 7'd0,   8'h00, 1'b1, NONE_IDLE},
        '{ROW_REQ, CMD_TICK,  7'd0,   8'h00, 1'b1, NONE_IDLE}
    };

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [BYTE_W-1:0]   cfg_wr_data = '0;
    logic                cmd_valid   = 1'b0;
    logic                cmd_stall;
    logic [CMD_W-1:0]    command     = CMD_LOAD;
    logic [STORE_AW-1:0] byte_index  = '0;
    logic [BYTE_W-1:0]   byte_value  = '0;
    logic                res_valid;
    logic                res_stall   = 1'b0;
    logic                serial_data;
    logic                bit_strobe;
    logic                latch_pulse;
    logic [ROW_W-1:0]    row_address;
    logic                active;

    // Shadow of the block's state, advanced once per accepted request.
    logic [BYTE_W-1:0]   store_img [STORE_DEPTH];
    int unsigned         shift_byte;
    logic [BIT_W-1:0]    shift_bit;
    logic [ROW_W-1:0]    row_img;
    logic [BYTE_W-1:0]   passes_img;
    bit                  running_img;
    logic [BYTE_W-1:0]   repeats_img;

    scan_result_t pending_scan [$];
    scan_result_t want_res;
    int           scan_faults       = 0;
    int           accepted_requests = 0;
    int           quiet_cycles      = 0;
    bit           quiet             = 1'b0;
    bit           send_idle_on      = 1'b1;
    bit           recv_idle_on      = 1'b1;
    bit           long_hold_done    = 1'b0;

    led_matrix_scan_driver #(
        .ROW_COUNT     (ROWS),
        .BYTES_PER_ROW (ROW_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .command     (command),
        .byte_index  (byte_index),
        .byte_value  (byte_value),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .serial_data (serial_data),
        .bit_strobe  (bit_strobe),
        .latch_pulse (latch_pulse),
        .row_address (row_address),
        .active      (active)
    );

    always #2 clk = ~clk;

    function automatic scan_result_t predict_scan(input logic [CMD_W-1:0] cmd,
                                                  input logic [STORE_AW-1:0] idx,
                                                  input logic [BYTE_W-1:0] val);
        scan_result_t r;
        logic [BYTE_W-1:0] cur;
        r = '0;
        case (cmd)
            CMD_LOAD:
                store_img[idx] = val;
            CMD_START:
            begin
                passes_img  = (repeats_img != 0) ? repeats_img - 8'd1 : 8'd0;
                running_img = (passes_img != 0);
                shift_byte  = 0;
                shift_bit   = '0;
            end
            CMD_TICK:
                if (running_img)
                begin
                    cur           = store_img[shift_byte % STORE_DEPTH];
                    r.serial_data = ~cur[7 - shift_bit];
                    r.bit_strobe  = 1'b1;
                    if (shift_bit != 3'd7)
                        shift_bit = shift_bit + 3'd1;
                    else
                    begin
                        shift_bit = '0;
                        if (shift_byte % ROW_BYTES == ROW_BYTES - 1)
                        begin
                            r.latch_pulse = 1'b1;
                            row_img       = ROW_W'((row_img + 1) % ROWS);
                        end
                        if (shift_byte + 1 >= FRAME_BYTES)
                        begin
                            shift_byte = 0;
                            if (passes_img != 0)
                                passes_img = passes_img - 8'd1;
                            running_img = (passes_img != 0);
                        end
                        else
                            shift_byte = shift_byte + 1;
                    end
                end
            default: ;
        endcase
        r.row_address = row_img;
        r.active      = running_img;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [3:0] want,
                                        input logic [3:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            scan_faults++;
        end
    endfunction

    task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [STORE_AW-1:0] idx,
                                 input logic [BYTE_W-1:0] val, input bit typed,
                                 input scan_result_t given);
        int gap;
        scan_result_t predicted;
        gap = 0;
        if (!quiet && send_idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 3);
        @(negedge clk);
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid  <= 1'b1;
        command    <= cmd;
        byte_index <= idx;
        byte_value <= val;
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
        predicted = predict_scan(cmd, idx, val);
        pending_scan.push_back(typed ? given : predicted);
        accepted_requests++;
        if ($urandom_range(0, 31) == 0)
            send_idle_on = !send_idle_on;
    endtask

    // Withdraws the request line and lets every outstanding result come back.
    task automatic drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_scan.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_repeats(input logic [BYTE_W-1:0] count);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        repeats_img = count;
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] count, input int requests,
                             input int start_permille, input bit fill_frame);
        int pick;
        logic [CMD_W-1:0] cmd;
        logic [BYTE_W-1:0] val;
        write_repeats(count);
        // A whole frame of fresh pixels makes the shifted data worth checking.
        if (fill_frame)
            for (int a = 0; a < FRAME_BYTES; a++)
                issue_request(CMD_LOAD, STORE_AW'(a), BYTE_W'($urandom), 1'b0, NONE_IDLE);
        issue_request(CMD_START, STORE_AW'($urandom), BYTE_W'($urandom), 1'b0, NONE_IDLE);
        repeat (requests)
        begin
            pick = $urandom_range(0, 999);
            if (pick < start_permille)
                cmd = CMD_START;
            else if (pick < start_permille + 20)
                cmd = CMD_RSVD;
            else if (pick < start_permille + 120)
                cmd = CMD_LOAD;
            else
                cmd = CMD_TICK;
            if ($urandom_range(0, 7) == 0)
                val = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                val = BYTE_W'($urandom);
            issue_request(cmd, STORE_AW'($urandom), val, 1'b0, NONE_IDLE);
        end
    endtask

    // Result side: short random stalls, and once a long hold-off so the block backs up.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && accepted_requests >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                res_stall <= 1'b0;
            end
            else if (!quiet && recv_idle_on && $urandom_range(0, 4) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                res_stall <= 1'b0;
            end
            if ($urandom_range(0, 49) == 0)
                recv_idle_on = !recv_idle_on;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_scan.size() == 0)
            begin
                $error("result returned with no request outstanding");
                scan_faults++;
            end
            else
            begin
                want_res = pending_scan.pop_front();
                check_field("serial_data", 4'(want_res.serial_data), 4'(serial_data));
                check_field("bit_strobe", 4'(want_res.bit_strobe), 4'(bit_strobe));
                check_field("latch_pulse", 4'(want_res.latch_pulse), 4'(latch_pulse));
                check_field("row_address", want_res.row_address, row_address);
                check_field("active", 4'(want_res.active), 4'(active));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        foreach (store_img[a])
            store_img[a] = '0;
        shift_byte  = 0;
        shift_bit   = '0;
        row_img     = '0;
        passes_img  = '0;
        running_img = 1'b0;
        repeats_img = REPEATS_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_repeats(plan[i].val);
            else
                issue_request(plan[i].cmd, plan[i].idx, plan[i].val, plan[i].typed,
                              plan[i].res);
        end

        // One full pass runs out here, so the block is seen returning to idle.
        run_phase(8'd2, 1250, 0, 1'b1);
        run_phase(8'd255, 300, 5, 1'b0);
        run_phase(8'd0, 60, 50, 1'b0);
        run_phase(8'd1, 60, 50, 1'b0);
        quiet = 1'b1;
        run_phase(BYTE_W'($urandom_range(3, 254)), 150, 20, 1'b0);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (scan_faults == 0 && pending_scan.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
